[rtl/usd_pkg.sv]
// ----------------------------------------------------------------------------
// usd_pkg
// Shared types and constants for the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package usd_pkg;

   localparam logic [20:0] REPLACEMENT_CP = 21'h00FFFD;
   localparam int          QUEUE_DEPTH    = 2;

   // input beat: one raw byte and its end-of-string flag
   typedef struct packed {
      logic [7:0] in_byte;
      logic       string_end;
   } req_type;

   // result beat: one code point
   typedef struct packed {
      logic [20:0] code_point;
      logic        run_last;
   } rsp_type;

   // work for the back end: cnt_m1 + 1 results, all U+FFFD but the last,
   // which carries tail
   typedef struct packed {
      logic [1:0]  cnt_m1;
      logic [20:0] tail;
   } job_type;

endpackage

[rtl/usd_front.sv]
// ----------------------------------------------------------------------------
// usd_front
// Byte classifier: tracks the open sequence and turns each byte into at most
// one job descriptor for the result serialiser.
// ----------------------------------------------------------------------------
module usd_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  usd_pkg::req_type  req_data,
   output logic              job_push,
   output usd_pkg::job_type  job_data,
   input  logic              job_ready
);
   import usd_pkg::*;

   logic [1:0]  needed_ff, needed_in;
   logic [1:0]  taken_ff, taken_in;
   logic [20:0] partial_ff, partial_in;

   logic [7:0]  b;
   logic        str_end;
   logic        accept;
   logic        is_cont;
   logic        seq_open;
   logic [1:0]  lead_need;
   logic [20:0] lead_bits;
   logic        fresh_emit;
   logic [20:0] fresh_val;
   logic [1:0]  taken_inc;
   logic [20:0] partial_shift;
   logic        emit;

   assign b         = req_data.in_byte;
   assign str_end   = req_data.string_end;
   assign req_ready = job_ready;
   assign accept    = req_valid && job_ready;
   assign is_cont   = (b[7:6] == 2'b10);
   assign seq_open  = (needed_ff != 2'd0);
   assign taken_inc = taken_ff + 2'd1;
   assign partial_shift = {partial_ff[14:0], b[5:0]};

   // lead byte pattern decode
   always_comb begin
      lead_need = 2'd0;
      lead_bits = '0;
      if (b[7:5] == 3'b110) begin
         lead_need = 2'd1;
         lead_bits = {16'd0, b[4:0]};
      end else if (b[7:4] == 4'b1110) begin
         lead_need = 2'd2;
         lead_bits = {17'd0, b[3:0]};
      end else if (b[7:3] == 5'b11110) begin
         lead_need = 2'd3;
         lead_bits = {18'd0, b[2:0]};
      end
   end

   // result of handling the byte afresh
   assign fresh_emit = !b[7] || (lead_need == 2'd0) || str_end;
   assign fresh_val  = b[7] ? REPLACEMENT_CP : {13'd0, b};

   // classify and compute next sequence state
   always_comb begin
      emit          = 1'b0;
      job_data      = '{cnt_m1: 2'd0, tail: REPLACEMENT_CP};
      needed_in     = needed_ff;
      taken_in      = taken_ff;
      partial_in    = partial_ff;
      if (seq_open && is_cont) begin
         if (taken_inc >= needed_ff) begin
            emit       = 1'b1;
            job_data   = '{cnt_m1: 2'd0, tail: partial_shift};
            needed_in  = 2'd0;
            taken_in   = 2'd0;
            partial_in = '0;
         end else if (str_end) begin
            emit       = 1'b1;
            job_data   = '{cnt_m1: taken_inc, tail: REPLACEMENT_CP};
            needed_in  = 2'd0;
            taken_in   = 2'd0;
            partial_in = '0;
         end else begin
            taken_in   = taken_inc;
            partial_in = partial_shift;
         end
      end else begin
         // flush of a broken sequence, then the byte as a lead
         if (seq_open) begin
            emit = 1'b1;
            if (fresh_emit) begin
               job_data = '{cnt_m1: taken_inc, tail: fresh_val};
            end else begin
               job_data = '{cnt_m1: taken_ff, tail: REPLACEMENT_CP};
            end
         end else begin
            emit     = fresh_emit;
            job_data = '{cnt_m1: 2'd0, tail: fresh_val};
         end
         if (!fresh_emit) begin
            needed_in  = lead_need;
            taken_in   = 2'd0;
            partial_in = lead_bits;
         end else begin
            needed_in  = 2'd0;
            taken_in   = 2'd0;
            partial_in = '0;
         end
      end
   end

   assign job_push = accept && emit;

   // sequence state
   always_ff @(posedge clock) begin
      if (reset) begin
         needed_ff  <= 2'd0;
         taken_ff   <= 2'd0;
         partial_ff <= '0;
      end else if (accept) begin
         needed_ff  <= needed_in;
         taken_ff   <= taken_in;
         partial_ff <= partial_in;
      end
   end

endmodule

[rtl/usd_queue.sv]
// ----------------------------------------------------------------------------
// usd_queue
// Two-entry job queue between the classifier and the serialiser.
// ----------------------------------------------------------------------------
module usd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  usd_pkg::job_type  push_data,
   output logic              ready,
   input  logic              pop,
   output logic              head_valid,
   output usd_pkg::job_type  head_data
);
   import usd_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   job_type               mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]        count_ff, count_in;
   logic                  do_push;
   logic                  do_pop;

   assign ready      = (count_ff != (PTR_W+1)'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = mem_ff[rd_ptr_ff];
   assign do_push    = push && ready;
   assign do_pop     = pop && head_valid;

   // pointer and fill count next values
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + (PTR_W+1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (PTR_W+1)'(1);
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[rtl/usd_back.sv]
// ----------------------------------------------------------------------------
// usd_back
// Result serialiser: expands each job into its result beats through a
// registered output stage.
// ----------------------------------------------------------------------------
module usd_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   input  usd_pkg::job_type  job_data,
   output logic              job_pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output usd_pkg::rsp_type  rsp_data
);
   import usd_pkg::*;

   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;
   logic [1:0]  idx_ff, idx_in;
   logic        load;
   logic        is_last;

   assign load    = !rsp_valid_ff || rsp_ready;
   assign is_last = (idx_ff == job_data.cnt_m1);
   assign job_pop = load && job_valid && is_last;

   // next beat
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      idx_in       = idx_ff;
      if (load) begin
         rsp_valid_in = job_valid;
         if (job_valid) begin
            rsp_in.code_point = is_last ? job_data.tail : REPLACEMENT_CP;
            rsp_in.run_last   = is_last;
            idx_in            = is_last ? 2'd0 : idx_ff + 2'd1;
         end
      end
   end

   // output payload
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   // output control and beat index
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         idx_ff       <= 2'd0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[rtl/utf8_stream_decoder.sv]
// Path: an accepted byte's job is written into the job queue, then its results
// leave through the registered output stage. Throughput: one byte per cycle while
// the two-job queue has room; a byte giving several results holds the serialiser.
// Reset: synchronous, active high; clears the open sequence, queue and output stage.
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// Streaming UTF-8 to code point decoder with U+FFFD for malformed input.
// ----------------------------------------------------------------------------
module utf8_stream_decoder (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  usd_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output usd_pkg::rsp_type  rsp_data
);
   import usd_pkg::*;

   logic    push;
   job_type push_data;
   logic    q_ready;
   logic    pop;
   logic    head_valid;
   job_type head_data;

   // classifier
   usd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .job_push  (push),
      .job_data  (push_data),
      .job_ready (q_ready)
   );

   // job queue
   usd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .ready      (q_ready),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   // serialiser
   usd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (head_valid),
      .job_data  (head_data),
      .job_pop   (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the UTF-8 stream decoder. Directed byte strings
// cover plain ASCII, each sequence length and each malformed case. Then
// random text of mostly well-formed characters with some noise is sent.
// Every accepted byte runs through a behavioural decoder that queues the
// code points it expects, and each result beat is checked against the
// oldest one. Sender bursts and receiver stalls vary throughout.
// ----------------------------------------------------------------------------
module tb_top;

   import usd_pkg::*;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // decoder state for prediction
   logic [1:0]  open_need  = 2'd0;
   logic [1:0]  open_taken = 2'd0;
   logic [20:0] open_code  = 21'd0;
   rsp_type     expected_cps[$];

   int mismatches    = 0;
   int bytes_sent    = 0;
   int burst_left    = 0;
   bit no_gaps       = 1'b0;
   int hold_requests = 0;
   int holds_done    = 0;
   int hold_left     = 0;
   int rx_cycle      = 0;
   int rx_mode       = 0;

   utf8_stream_decoder u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #10 clock = ~clock;

   // generous limit on the whole run
   initial begin
      #4000000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // ------------------------------------------------------------------------
   // behavioural decoder
   // ------------------------------------------------------------------------

   function automatic void push_cp(input logic [20:0] cp);
      rsp_type r;
      r.code_point = cp;
      r.run_last   = 1'b0;
      expected_cps.push_back(r);
   endfunction

   function automatic void close_seq();
      open_need  = 2'd0;
      open_taken = 2'd0;
      open_code  = 21'd0;
   endfunction

   // one replacement for the lead plus one per continuation taken
   function automatic void flush_open();
      push_cp(REPLACEMENT_CP);
      for (int k = 0; k < open_taken; k++)
         push_cp(REPLACEMENT_CP);
      close_seq();
   endfunction

   function automatic void decode_byte(input logic [7:0] b, input logic last);
      int          first;
      logic        fresh;
      logic [1:0]  need;
      logic [20:0] bits;
      rsp_type     r;
      first = expected_cps.size();
      fresh = 1'b1;
      // open sequence: continuation or abort
      if (open_need != 2'd0) begin
         if (b[7:6] == 2'b10) begin
            fresh      = 1'b0;
            open_code  = {open_code[14:0], b[5:0]};
            open_taken = open_taken + 2'd1;
            if (open_taken >= open_need) begin
               push_cp(open_code);
               close_seq();
            end else if (last) begin
               flush_open();
            end
         end else begin
            flush_open();
         end
      end
      // byte taken as a lead or plain character
      if (fresh) begin
         if (!b[7]) begin
            push_cp({13'd0, b});
         end else begin
            need = 2'd0;
            bits = 21'd0;
            casez (b)
               8'b110?????: begin
                  need = 2'd1;
                  bits = {16'd0, b[4:0]};
               end
               8'b1110????: begin
                  need = 2'd2;
                  bits = {17'd0, b[3:0]};
               end
               8'b11110???: begin
                  need = 2'd3;
                  bits = {18'd0, b[2:0]};
               end
               default: ;
            endcase
            if (need == 2'd0 || last) begin
               push_cp(REPLACEMENT_CP);
            end else begin
               open_need  = need;
               open_taken = 2'd0;
               open_code  = bits;
            end
         end
      end
      // flag the final code point of this byte
      if (expected_cps.size() > first) begin
         r = expected_cps.pop_back();
         r.run_last = 1'b1;
         expected_cps.push_back(r);
      end
   endfunction

   // ------------------------------------------------------------------------
   // result checking
   // ------------------------------------------------------------------------

   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_cps.size() == 0) begin
            $display("%0t: unexpected beat, expected none, got cp=%h last=%b",
                     $time, rsp_data.code_point, rsp_data.run_last);
            mismatches++;
         end else begin
            want = expected_cps.pop_front();
            if (rsp_data.code_point !== want.code_point) begin
               $display("%0t: code_point expected %h, got %h",
                        $time, want.code_point, rsp_data.code_point);
               mismatches++;
            end
            if (rsp_data.run_last !== want.run_last) begin
               $display("%0t: run_last expected %b, got %b",
                        $time, want.run_last, rsp_data.run_last);
               mismatches++;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // receiver: long hold on request, otherwise a changing stall pattern
   // ------------------------------------------------------------------------

   always @(posedge clock) begin
      rx_cycle = rx_cycle + 1;
      if (rx_cycle % 40 == 0)
         rx_mode = $urandom_range(0, 3);
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (hold_requests != holds_done) begin
         holds_done = holds_done + 1;
         hold_left  = 60;
         rsp_ready <= 1'b0;
      end else begin
         case (rx_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= ($urandom_range(0, 3) != 0);
            2: rsp_ready <= ($urandom_range(0, 2) == 0);
            default: rsp_ready <= ((rx_cycle % 8) < 5);
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // sender
   // ------------------------------------------------------------------------

   // offer one beat, holding it until accepted; gaps fall between bursts
   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = no_gaps ? 0 : $urandom_range(0, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid           <= 1'b1;
      req_data.in_byte    <= b;
      req_data.string_end <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      decode_byte(b, last);
      bytes_sent++;
      burst_left--;
   endtask

   // mostly well-formed characters, some cut short, some raw noise
   task automatic send_random_char();
      int          kind;
      int          nb;
      int          taken;
      logic        last;
      logic        cut_at_end;
      logic [20:0] cp;
      kind = $urandom_range(0, 99);
      last = ($urandom_range(0, 7) == 0);
      cp   = 21'($urandom);
      if (kind < 75) begin
         nb = $urandom_range(1, 4);
         case (nb)
            1: send_byte({1'b0, cp[6:0]}, last);
            2: begin
               send_byte({3'b110, cp[10:6]}, 1'b0);
               send_byte({2'b10, cp[5:0]}, last);
            end
            3: begin
               send_byte({4'b1110, cp[15:12]}, 1'b0);
               send_byte({2'b10, cp[11:6]}, 1'b0);
               send_byte({2'b10, cp[5:0]}, last);
            end
            default: begin
               send_byte({5'b11110, cp[20:18]}, 1'b0);
               send_byte({2'b10, cp[17:12]}, 1'b0);
               send_byte({2'b10, cp[11:6]}, 1'b0);
               send_byte({2'b10, cp[5:0]}, last);
            end
         endcase
      end else if (kind < 88) begin
         // truncated sequence, closed by end of string or a random byte
         nb         = $urandom_range(2, 4);
         taken      = $urandom_range(0, nb - 2);
         cut_at_end = 1'($urandom_range(0, 1));
         case (nb)
            2:       send_byte({3'b110, cp[4:0]}, cut_at_end && taken == 0);
            3:       send_byte({4'b1110, cp[3:0]}, cut_at_end && taken == 0);
            default: send_byte({5'b11110, cp[2:0]}, cut_at_end && taken == 0);
         endcase
         for (int k = 1; k <= taken; k++)
            send_byte({2'b10, 6'($urandom)}, cut_at_end && k == taken);
         if (!cut_at_end)
            send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end else begin
         send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
   endtask

   // stop offering and wait for every expected code point
   task automatic wait_results_done();
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (expected_cps.size() != 0) @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------

   task automatic test_ascii_bytes();
      send_byte(8'h00, 1'b0);
      send_byte(8'h7F, 1'b1);
   endtask

   // two, three and four byte forms, the last one the largest value a four byte form carries
   task automatic test_valid_sequences();
      send_byte(8'hC2, 1'b0);
      send_byte(8'hA9, 1'b0);
      send_byte(8'hE2, 1'b0);
      send_byte(8'h82, 1'b0);
      send_byte(8'hAC, 1'b0);
      send_byte(8'hF7, 1'b0);
      send_byte(8'hBF, 1'b0);
      send_byte(8'hBF, 1'b0);
      send_byte(8'hBF, 1'b1);
   endtask

   task automatic test_malformed_input();
      // bad continuation, then the byte again as plain ASCII
      send_byte(8'hE2, 1'b0);
      send_byte(8'h41, 1'b0);
      // string ends inside an open sequence
      send_byte(8'hF0, 1'b0);
      send_byte(8'h9F, 1'b1);
      // lead byte as the final byte
      send_byte(8'hC3, 1'b1);
      // stray continuation and invalid leads
      send_byte(8'h80, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hF8, 1'b0);
      // two continuations taken, then an invalid lead: four replacements
      send_byte(8'hF0, 1'b0);
      send_byte(8'h90, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'hFF, 1'b1);
   endtask

   task automatic test_random_text(input int count);
      int target;
      target = bytes_sent + count;
      while (bytes_sent < target) send_random_char();
   endtask

   // receiver holds off while the sender keeps offering back to back
   task automatic test_input_stall();
      no_gaps = 1'b1;
      hold_requests <= hold_requests + 1;
      test_random_text(30);
      no_gaps = 1'b0;
   endtask

   // sender pauses until the decoder has drained, then resumes
   task automatic test_idle_pause();
      wait_results_done();
      test_random_text(40);
   endtask

   initial begin
      int guard;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_ascii_bytes();
      test_valid_sequences();
      test_malformed_input();
      test_random_text(140);
      test_input_stall();
      test_idle_pause();

      // drain, then wait on for any stray beats
      req_valid <= 1'b0;
      guard = 0;
      while (expected_cps.size() != 0 && guard < 20000) begin
         @(posedge clock);
         guard++;
      end
      repeat (10) @(posedge clock);
      if (expected_cps.size() != 0)
         $display("%0t: %0d code points never arrived, next expected %h",
                  $time, expected_cps.size(), expected_cps[0].code_point);

      if (mismatches == 0 && expected_cps.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

[files.f]
rtl/usd_pkg.sv
rtl/usd_front.sv
rtl/usd_queue.sv
rtl/usd_back.sv
rtl/utf8_stream_decoder.sv
bench/tb_top.sv
